// ===== rtl/rspd_pkg.sv =====
// ----------------------------------------------------------------------------
// rspd_pkg: shared types and constants
// Packet scan phases, field phases, command codes and the parse-to-decode record.
// ----------------------------------------------------------------------------
`default_nettype none
package rspd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT, PH_PAYLOAD, PH_CK1, PH_CK2_HEX, PH_CK2_NONE
    } scan_phase_t;

    typedef enum logic [2:0] {
        FP_IDLE, FP_ADDR, FP_SEEK, FP_SIZE, FP_COLON, FP_DATA, FP_DONE
    } field_phase_t;

    localparam int NUM_LIT = 11;
    localparam int LIT_QSUP  = 0;
    localparam int LIT_HG    = 1;
    localparam int LIT_HC    = 2;
    localparam int LIT_QC    = 3;
    localparam int LIT_QATT  = 4;
    localparam int LIT_QOFF  = 5;
    localparam int LIT_QTST  = 6;
    localparam int LIT_QTFV  = 7;
    localparam int LIT_QTFP  = 8;
    localparam int LIT_QSYM  = 9;
    localparam int LIT_VCONT = 10;
    localparam int LIT_MAXLEN = 36;

    localparam logic [1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLS_CANNED  = 2'd1;
    localparam logic [1:0] CLS_TARGET  = 2'd2;

    localparam logic [4:0] CMD_UNKNOWN = 5'd0;
    localparam logic [4:0] CMD_QSUP    = 5'd1;
    localparam logic [4:0] CMD_H       = 5'd2;
    localparam logic [4:0] CMD_QMARK   = 5'd3;
    localparam logic [4:0] CMD_QC      = 5'd4;
    localparam logic [4:0] CMD_QATT    = 5'd5;
    localparam logic [4:0] CMD_QOFF    = 5'd6;
    localparam logic [4:0] CMD_QTST    = 5'd7;
    localparam logic [4:0] CMD_QTF     = 5'd8;
    localparam logic [4:0] CMD_G       = 5'd9;
    localparam logic [4:0] CMD_P_RD    = 5'd10;
    localparam logic [4:0] CMD_M_RD    = 5'd11;
    localparam logic [4:0] CMD_QSYM    = 5'd12;
    localparam logic [4:0] CMD_VCONT   = 5'd13;
    localparam logic [4:0] CMD_M_WR    = 5'd14;
    localparam logic [4:0] CMD_P_WR    = 5'd15;
    localparam logic [4:0] CMD_Z0_CLR  = 5'd16;
    localparam logic [4:0] CMD_ZW_CLR  = 5'd17;
    localparam logic [4:0] CMD_Z0_SET  = 5'd18;
    localparam logic [4:0] CMD_ZW_SET  = 5'd19;
    localparam logic [4:0] CMD_STEP    = 5'd20;
    localparam logic [4:0] CMD_CONT    = 5'd21;
    localparam logic [4:0] CMD_DETACH  = 5'd22;

    // one completed packet, handed from the parser to the decoder
    typedef struct packed {
        logic        ack_ok;
        logic [7:0]  f0;
        logic [7:0]  f1;
        logic        one;
        logic [NUM_LIT-1:0] hits;
        logic [1:0]  size_digit;
        logic [31:0] addr;
        logic [31:0] data;
    } pkt_rec_t;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= "0" && c <= "9") r = {1'b0, 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f") r = {1'b0, 4'(c - 8'h57)};
        else if (c >= "A" && c <= "F") r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [5:0] lit_len(input int i);
        logic [5:0] r;
        case (i)
            LIT_QSUP:  r = 6'd36;
            LIT_HG:    r = 6'd3;
            LIT_HC:    r = 6'd4;
            LIT_QC:    r = 6'd2;
            LIT_QATT:  r = 6'd9;
            LIT_QOFF:  r = 6'd8;
            LIT_QTST:  r = 6'd8;
            LIT_QTFV:  r = 6'd4;
            LIT_QTFP:  r = 6'd4;
            LIT_QSYM:  r = 6'd9;
            LIT_VCONT: r = 6'd6;
            default:   r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] str_char(input string s, input int p);
        logic [7:0] r;
        r = 8'h00;
        if (p < s.len()) r = s[p];
        return r;
    endfunction

    function automatic logic [7:0] lit_char(input int i, input logic [5:0] pos);
        logic [7:0] r;
        int p;
        p = int'(pos);
        case (i)
            LIT_QSUP:  r = str_char("qSupported:multiprocess+;qRelocInsn+", p);
            LIT_HG:    r = str_char("Hg0", p);
            LIT_HC:    r = str_char("Hc-1", p);
            LIT_QC:    r = str_char("qC", p);
            LIT_QATT:  r = str_char("qAttached", p);
            LIT_QOFF:  r = str_char("qOffsets", p);
            LIT_QTST:  r = str_char("qTStatus", p);
            LIT_QTFV:  r = str_char("qTfV", p);
            LIT_QTFP:  r = str_char("qTfP", p);
            LIT_QSYM:  r = str_char("qSymbol::", p);
            LIT_VCONT: r = str_char("vCont?", p);
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rspd_parser.sv =====
// ----------------------------------------------------------------------------
// rspd_parser: packet framing and field capture
// Hunts for start, sums and matches payload bytes, captures hex fields and checksum.
// ----------------------------------------------------------------------------
`default_nettype none
module rspd_parser
    import rspd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_valid,
    input  wire logic [7:0] rx_byte,
    output logic            rec_valid,
    output pkt_rec_t        rec
);
    localparam int PW = $clog2(MAX_PAYLOAD + 1);

    scan_phase_t        phase_reg, phase_next;
    field_phase_t       fp_reg, fp_next;
    logic [7:0]         sum_reg, sum_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [7:0]         f0_reg, f0_next, f1_reg, f1_next;
    logic [15:0]        flags_reg, flags_next;
    logic [31:0]        addr_reg, addr_next, data_reg, data_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [7:0]         ck_reg, ck_next;
    logic [1:0]         sz_reg, sz_next;

    logic [4:0]  hv;
    logic        is_hex, full, has_sep;
    logic [7:0]  sep, f0c, f1c, ck_final;
    logic [NUM_LIT-1:0] hits;
    logic [5:0]  pos6;
    logic        pos_fits;

    always_comb begin
        hv = hex_val(rx_byte);
        is_hex = !hv[4];
        full = (f0_reg == "M") && (cnt_reg >= 4'd8);
        has_sep = (f0_reg == "P") || (f0_reg == "m") || (f0_reg == "M");
        sep = (f0_reg == "P") ? "=" : ",";
        pos_fits = (pos_reg < PW'(LIT_MAXLEN));
        pos6 = pos_fits ? 6'(pos_reg) : 6'd63;
        f0c = f0_reg;
        f1c = f1_reg;
        if (pos_reg == '0) f0c = rx_byte;
        if (pos_reg == PW'(1)) f1c = rx_byte;
        for (int i = 0; i < NUM_LIT; i++) begin
            hits[i] = flags_reg[i] && (pos_reg == PW'(lit_len(i)));
        end
        ck_final = ck_reg;
        if (phase_reg == PH_CK2_HEX && is_hex) ck_final = {ck_reg[3:0], hv[3:0]};
    end

    always_comb begin
        phase_next = phase_reg;
        fp_next = fp_reg;
        sum_next = sum_reg;
        pos_next = pos_reg;
        f0_next = f0_reg;
        f1_next = f1_reg;
        flags_next = flags_reg;
        addr_next = addr_reg;
        data_next = data_reg;
        cnt_next = cnt_reg;
        ck_next = ck_reg;
        sz_next = sz_reg;
        rec_valid = 1'b0;
        if (byte_valid) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == "$") begin
                        phase_next = PH_PAYLOAD;
                        fp_next = FP_IDLE;
                        sum_next = '0;
                        pos_next = '0;
                        f0_next = '0;
                        f1_next = '0;
                        flags_next = '1;
                        addr_next = '0;
                        data_next = '0;
                        cnt_next = '0;
                        ck_next = '0;
                        sz_next = '0;
                    end
                end
                PH_PAYLOAD: begin
                    if (rx_byte == "#") begin
                        phase_next = PH_CK1;
                    end else begin
                        sum_next = sum_reg + rx_byte;
                        if (pos_reg < PW'(MAX_PAYLOAD)) begin
                            f0_next = f0c;
                            f1_next = f1c;
                            for (int i = 0; i < NUM_LIT; i++) begin
                                if (!pos_fits || pos6 >= lit_len(i) ||
                                    lit_char(i, pos6) != rx_byte) begin
                                    flags_next[i] = 1'b0;
                                end
                            end
                            case (fp_reg)
                                FP_ADDR: begin
                                    if (is_hex && !full) begin
                                        addr_next = {addr_reg[27:0], hv[3:0]};
                                        if (cnt_reg < 4'd15) cnt_next = cnt_reg + 4'd1;
                                    end else if (has_sep && rx_byte == sep) begin
                                        if (f0_reg == "M") fp_next = FP_SIZE;
                                        else begin
                                            fp_next = FP_DATA;
                                            cnt_next = '0;
                                        end
                                    end else begin
                                        fp_next = has_sep ? FP_SEEK : FP_DONE;
                                    end
                                end
                                FP_SEEK: begin
                                    if (has_sep && rx_byte == sep) begin
                                        if (f0_reg == "M") fp_next = FP_SIZE;
                                        else begin
                                            fp_next = FP_DATA;
                                            cnt_next = '0;
                                        end
                                    end
                                end
                                FP_SIZE: begin
                                    if (rx_byte >= "1" && rx_byte <= "3") sz_next = rx_byte[1:0];
                                    if (rx_byte == ":") begin
                                        fp_next = FP_DATA;
                                        cnt_next = '0;
                                    end else begin
                                        fp_next = FP_COLON;
                                    end
                                end
                                FP_COLON: begin
                                    if (rx_byte == ":") begin
                                        fp_next = FP_DATA;
                                        cnt_next = '0;
                                    end
                                end
                                FP_DATA: begin
                                    if (is_hex && !full) begin
                                        data_next = {data_reg[27:0], hv[3:0]};
                                        if (cnt_reg < 4'd15) cnt_next = cnt_reg + 4'd1;
                                    end else begin
                                        fp_next = FP_DONE;
                                    end
                                end
                                default: ;
                            endcase
                            if (pos_reg == '0 && (rx_byte == "p" || rx_byte == "m" ||
                                                  rx_byte == "M" || rx_byte == "P")) begin
                                fp_next = FP_ADDR;
                                cnt_next = '0;
                            end
                            if (pos_reg == PW'(2) && (f0_reg == "z" || f0_reg == "Z") &&
                                (f1_reg == "0" || f1_reg == "2" || f1_reg == "3" ||
                                 f1_reg == "4")) begin
                                fp_next = FP_ADDR;
                                cnt_next = '0;
                            end
                            pos_next = pos_reg + PW'(1);
                        end
                    end
                end
                PH_CK1: begin
                    if (is_hex) begin
                        ck_next = {4'd0, hv[3:0]};
                        phase_next = PH_CK2_HEX;
                    end else begin
                        ck_next = '0;
                        phase_next = PH_CK2_NONE;
                    end
                end
                PH_CK2_HEX, PH_CK2_NONE: begin
                    rec_valid = 1'b1;
                    phase_next = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        rec.ack_ok = (sum_reg == ck_final);
        rec.f0 = f0_reg;
        rec.f1 = f1_reg;
        rec.one = (pos_reg == PW'(1));
        rec.hits = hits;
        rec.size_digit = sz_reg;
        rec.addr = addr_reg;
        rec.data = data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            fp_reg <= FP_IDLE;
            sum_reg <= '0;
            pos_reg <= '0;
            f0_reg <= '0;
            f1_reg <= '0;
            flags_reg <= '1;
            addr_reg <= '0;
            data_reg <= '0;
            cnt_reg <= '0;
            ck_reg <= '0;
            sz_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            fp_reg <= fp_next;
            sum_reg <= sum_next;
            pos_reg <= pos_next;
            f0_reg <= f0_next;
            f1_reg <= f1_next;
            flags_reg <= flags_next;
            addr_reg <= addr_next;
            data_reg <= data_next;
            cnt_reg <= cnt_next;
            ck_reg <= ck_next;
            sz_reg <= sz_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rspd_queue.sv =====
// ----------------------------------------------------------------------------
// rspd_queue: two-entry packet record queue
// Decouples the byte parser from the command decoder and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module rspd_queue
    import rspd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_valid,
    input  pkt_rec_t      wr_rec,
    output logic          wr_ready,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output pkt_rec_t      rd_rec
);
    pkt_rec_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    always_comb begin
        wr_ready = (cnt_reg != 2'd2);
        rd_valid = (cnt_reg != 2'd0);
        rd_rec = mem_reg[rp_reg];
        do_wr = wr_valid && wr_ready;
        do_rd = rd_valid && rd_ready;
        wp_next = do_wr ? !wp_reg : wp_reg;
        rp_next = do_rd ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rspd_decoder.sv =====
// ----------------------------------------------------------------------------
// rspd_decoder: command classification and output register
// Maps a packet record to class, command and fields; holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module rspd_decoder
    import rspd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  pkt_rec_t    in_rec,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [73:0] out_word
);
    logic        valid_reg;
    logic [73:0] word_reg, word_next;
    logic [1:0]  cls, ws;
    logic [4:0]  cmd;
    logic [31:0] a, dt;
    logic [7:0]  f0, f1;
    logic        one, kind;

    always_comb begin
        f0 = in_rec.f0;
        f1 = in_rec.f1;
        one = in_rec.one;
        kind = (f1 == "2" || f1 == "3" || f1 == "4");
        cls = CLS_UNKNOWN; cmd = CMD_UNKNOWN; ws = '0; a = '0; dt = '0;
        if (in_rec.hits[LIT_QSUP]) begin cls = CLS_CANNED; cmd = CMD_QSUP; end
        else if (in_rec.hits[LIT_HG] || in_rec.hits[LIT_HC]) begin
            cls = CLS_CANNED; cmd = CMD_H;
        end
        else if (one && f0 == "?") begin cls = CLS_CANNED; cmd = CMD_QMARK; end
        else if (in_rec.hits[LIT_QC]) begin cls = CLS_CANNED; cmd = CMD_QC; end
        else if (in_rec.hits[LIT_QATT]) begin cls = CLS_CANNED; cmd = CMD_QATT; end
        else if (in_rec.hits[LIT_QOFF]) begin cls = CLS_CANNED; cmd = CMD_QOFF; end
        else if (in_rec.hits[LIT_QTST]) begin cls = CLS_CANNED; cmd = CMD_QTST; end
        else if (in_rec.hits[LIT_QTFV] || in_rec.hits[LIT_QTFP]) begin
            cls = CLS_CANNED; cmd = CMD_QTF;
        end
        else if (one && f0 == "g") begin cls = CLS_TARGET; cmd = CMD_G; end
        else if (f0 == "p") begin cls = CLS_TARGET; cmd = CMD_P_RD; a = in_rec.addr; end
        else if (f0 == "m") begin
            cls = CLS_TARGET; cmd = CMD_M_RD; a = in_rec.addr; dt = in_rec.data;
        end
        else if (in_rec.hits[LIT_QSYM]) begin cls = CLS_CANNED; cmd = CMD_QSYM; end
        else if (in_rec.hits[LIT_VCONT]) begin cls = CLS_CANNED; cmd = CMD_VCONT; end
        else if (f0 == "M") begin
            cls = CLS_TARGET; cmd = CMD_M_WR; ws = in_rec.size_digit;
            a = in_rec.addr; dt = in_rec.data;
        end
        else if (f0 == "P") begin
            cls = CLS_TARGET; cmd = CMD_P_WR; a = in_rec.addr; dt = in_rec.data;
        end
        else if (f0 == "z" && f1 == "0") begin
            cls = CLS_TARGET; cmd = CMD_Z0_CLR; a = in_rec.addr;
        end
        else if (f0 == "z" && kind) begin
            cls = CLS_TARGET; cmd = CMD_ZW_CLR; a = in_rec.addr; dt = {24'd0, f1 - 8'h30};
        end
        else if (f0 == "Z" && f1 == "0") begin
            cls = CLS_TARGET; cmd = CMD_Z0_SET; a = in_rec.addr;
        end
        else if (f0 == "Z" && kind) begin
            cls = CLS_TARGET; cmd = CMD_ZW_SET; a = in_rec.addr; dt = {24'd0, f1 - 8'h31};
        end
        else if (one && f0 == "s") begin cls = CLS_TARGET; cmd = CMD_STEP; end
        else if ((one && f0 == "c") || (f0 == "C" && f1 == "0")) begin
            cls = CLS_TARGET; cmd = CMD_CONT;
        end
        else if (one && (f0 == "D" || f0 == "k")) begin cls = CLS_TARGET; cmd = CMD_DETACH; end
        word_next = {dt, a, ws, cmd, cls, in_rec.ack_ok};
        in_ready = !valid_reg || out_ready;
        out_valid = valid_reg;
        out_word = word_reg;
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) word_reg <= word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (in_ready) valid_reg <= in_valid;
    end
endmodule
`default_nettype wire

// ===== rtl/rsp_packet_receive_decode_top.sv =====
// ----------------------------------------------------------------------------
// rsp_packet_receive_decode_top: debug-link packet receiver and decoder
// Takes one character per cycle while s_tready is high; one decoded result per completed packet.
// Path: the queue takes the record at the edge that accepts the second checksum
// byte; the decoder then registers the result word from the queue head.
// Throughput: one byte per cycle; input stalls only when queue and output are full.
// Reset: aresetn synchronous active low; parser returns to hunting for start.
// ----------------------------------------------------------------------------
`default_nettype none
module rsp_packet_receive_decode_top
    import rspd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // ack_ok, request_class[2:1], command[7:3], write_size[9:8],
    // address[41:10], data[73:42], zero pad to 80
    output logic [79:0]      m_tdata
);
    logic     rec_valid, q_ready, q_valid, d_ready;
    pkt_rec_t rec, q_rec;
    logic [73:0] word;

    assign s_tready = q_ready;

    rspd_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .byte_valid(s_tvalid && q_ready), .rx_byte(s_tdata),
        .rec_valid(rec_valid), .rec(rec)
    );

    rspd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(rec_valid), .wr_rec(rec), .wr_ready(q_ready),
        .rd_valid(q_valid), .rd_ready(d_ready), .rd_rec(q_rec)
    );

    rspd_decoder u_decoder (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(d_ready), .in_rec(q_rec),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_word(word)
    );

    assign m_tdata = {6'd0, word};
endmodule
`default_nettype wire

// ===== verif/rsp_packet_receive_decode_top_test.sv =====
// ----------------------------------------------------------------------------
// rsp_packet_receive_decode_top_test: packet receive and decode testbench
// Sends debug-link packets byte by byte through the input stream. A parser
// model in the bench predicts each decoded result. The bench compares every
// result word field by field in order, with random idling and output stalls.
// ----------------------------------------------------------------------------
module rsp_packet_receive_decode_top_test;
    import rspd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        ack_ok;
        logic [1:0]  req_class;
        logic [4:0]  command;
        logic [1:0]  write_size;
        logic [31:0] address;
        logic [31:0] data;
    } decoded_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    rsp_packet_receive_decode_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------- packet decoder model ----------------
    localparam int PAYLOAD_LIMIT = 1024;
    string lit_str [NUM_LIT] = '{
        "qSupported:multiprocess+;qRelocInsn+", "Hg0", "Hc-1", "qC", "qAttached",
        "qOffsets", "qTStatus", "qTfV", "qTfP", "qSymbol::", "vCont?"
    };

    scan_phase_t        scan;
    field_phase_t       fld;
    logic [7:0]         pay_sum, ck_rx, ch0, ch1;
    int                 pay_pos, dig_cnt;
    logic [NUM_LIT-1:0] lit_live;
    logic [31:0]        addr_acc, data_acc;
    logic [1:0]         size_dig;

    decoded_t decoded_q[$];
    bit       failed = 0;

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    function automatic void clear_packet();
        pay_sum = 0; pay_pos = 0; ch0 = 0; ch1 = 0; lit_live = '1;
        fld = FP_IDLE; addr_acc = 0; data_acc = 0; dig_cnt = 0; ck_rx = 0;
        size_dig = 0;
    endfunction

    function automatic bit lit_matched(int i);
        return lit_live[i] && pay_pos == lit_str[i].len();
    endfunction

    function automatic void separator_seen();
        if (ch0 == "M") fld = FP_SIZE;
        else begin
            fld = FP_DATA; dig_cnt = 0;
        end
    endfunction

    function automatic void field_byte(logic [7:0] c);
        int  d;
        bit  full;
        int  sep;
        d = hex_digit(c);
        full = (ch0 == "M") && dig_cnt >= 8;
        sep = (ch0 == "P") ? "=" : ((ch0 == "m" || ch0 == "M") ? "," : -1);
        case (fld)
            FP_ADDR: begin
                if (d >= 0 && !full) begin
                    addr_acc = {addr_acc[27:0], 4'(d)};
                    if (dig_cnt < 15) dig_cnt++;
                end else if (int'(c) == sep) separator_seen();
                else fld = (sep < 0) ? FP_DONE : FP_SEEK;
            end
            FP_SEEK: if (int'(c) == sep) separator_seen();
            FP_SIZE: begin
                if (c >= "1" && c <= "3") size_dig = 2'(c - 8'h30);
                if (c == ":") begin
                    fld = FP_DATA; dig_cnt = 0;
                end else fld = FP_COLON;
            end
            FP_COLON: if (c == ":") begin
                fld = FP_DATA; dig_cnt = 0;
            end
            FP_DATA: begin
                if (d >= 0 && !full) begin
                    data_acc = {data_acc[27:0], 4'(d)};
                    if (dig_cnt < 15) dig_cnt++;
                end else fld = FP_DONE;
            end
            default: ;
        endcase
    endfunction

    function automatic void payload_in(logic [7:0] c);
        pay_sum += c;
        if (pay_pos >= PAYLOAD_LIMIT) return;
        if (pay_pos == 0) ch0 = c;
        else if (pay_pos == 1) ch1 = c;
        for (int i = 0; i < NUM_LIT; i++)
            if (lit_live[i] && (pay_pos >= lit_str[i].len() ||
                                8'(lit_str[i][pay_pos]) != c))
                lit_live[i] = 1'b0;
        field_byte(c);
        if (pay_pos == 0 && (c == "p" || c == "m" || c == "M" || c == "P")) begin
            fld = FP_ADDR; dig_cnt = 0;
        end
        if (pay_pos == 2 && (ch0 == "z" || ch0 == "Z") &&
            (ch1 == "0" || ch1 == "2" || ch1 == "3" || ch1 == "4")) begin
            fld = FP_ADDR; dig_cnt = 0;
        end
        pay_pos++;
    endfunction

    function automatic decoded_t decode_packet();
        decoded_t r;
        bit one, kind;
        one = (pay_pos == 1);
        kind = (ch1 == "2" || ch1 == "3" || ch1 == "4");
        r = '0;
        r.ack_ok = (pay_sum == ck_rx);
        if (lit_matched(LIT_QSUP)) {r.req_class, r.command} = {CLS_CANNED, CMD_QSUP};
        else if (lit_matched(LIT_HG) || lit_matched(LIT_HC))
            {r.req_class, r.command} = {CLS_CANNED, CMD_H};
        else if (one && ch0 == "?") {r.req_class, r.command} = {CLS_CANNED, CMD_QMARK};
        else if (lit_matched(LIT_QC)) {r.req_class, r.command} = {CLS_CANNED, CMD_QC};
        else if (lit_matched(LIT_QATT)) {r.req_class, r.command} = {CLS_CANNED, CMD_QATT};
        else if (lit_matched(LIT_QOFF)) {r.req_class, r.command} = {CLS_CANNED, CMD_QOFF};
        else if (lit_matched(LIT_QTST)) {r.req_class, r.command} = {CLS_CANNED, CMD_QTST};
        else if (lit_matched(LIT_QTFV) || lit_matched(LIT_QTFP))
            {r.req_class, r.command} = {CLS_CANNED, CMD_QTF};
        else if (one && ch0 == "g") {r.req_class, r.command} = {CLS_TARGET, CMD_G};
        else if (ch0 == "p") begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_P_RD}; r.address = addr_acc;
        end else if (ch0 == "m") begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_M_RD};
            r.address = addr_acc; r.data = data_acc;
        end else if (lit_matched(LIT_QSYM)) {r.req_class, r.command} = {CLS_CANNED, CMD_QSYM};
        else if (lit_matched(LIT_VCONT))
            {r.req_class, r.command} = {CLS_CANNED, CMD_VCONT};
        else if (ch0 == "M") begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_M_WR};
            r.write_size = size_dig; r.address = addr_acc; r.data = data_acc;
        end else if (ch0 == "P") begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_P_WR};
            r.address = addr_acc; r.data = data_acc;
        end else if (ch0 == "z" && ch1 == "0") begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_Z0_CLR}; r.address = addr_acc;
        end else if (ch0 == "z" && kind) begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_ZW_CLR};
            r.address = addr_acc; r.data = 32'(ch1 - 8'h30);
        end else if (ch0 == "Z" && ch1 == "0") begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_Z0_SET}; r.address = addr_acc;
        end else if (ch0 == "Z" && kind) begin
            {r.req_class, r.command} = {CLS_TARGET, CMD_ZW_SET};
            r.address = addr_acc; r.data = 32'(ch1 - 8'h31);
        end else if (one && ch0 == "s") {r.req_class, r.command} = {CLS_TARGET, CMD_STEP};
        else if ((one && ch0 == "c") || (ch0 == "C" && ch1 == "0"))
            {r.req_class, r.command} = {CLS_TARGET, CMD_CONT};
        else if (one && (ch0 == "D" || ch0 == "k"))
            {r.req_class, r.command} = {CLS_TARGET, CMD_DETACH};
        return r;
    endfunction

    function automatic void rx_char(logic [7:0] c);
        int d;
        d = hex_digit(c);
        case (scan)
            PH_HUNT: if (c == "$") begin
                clear_packet(); scan = PH_PAYLOAD;
            end
            PH_PAYLOAD: if (c == "#") scan = PH_CK1; else payload_in(c);
            PH_CK1: begin
                ck_rx = (d >= 0) ? 8'(d) : 8'h00;
                scan = (d >= 0) ? PH_CK2_HEX : PH_CK2_NONE;
            end
            default: begin
                if (scan == PH_CK2_HEX && d >= 0) ck_rx = {ck_rx[3:0], 4'(d)};
                decoded_q.push_back(decode_packet());
                clear_packet();
                scan = PH_HUNT;
            end
        endcase
    endfunction

    // ---------------- stream drivers ----------------
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    task automatic send_byte(logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        do @(posedge aclk); while (!s_tready);
        rx_char(b);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // check mode: 0 correct, 1 wrong, 2 non-hex first char, 3 non-hex second char
    task automatic send_packet(string pl, int ck_mode);
        logic [7:0] sum;
        string hx;
        sum = 0;
        for (int i = 0; i < pl.len(); i++) sum += 8'(pl[i]);
        if (ck_mode == 1) sum += 8'($urandom_range(1, 255));
        hx = $sformatf("%02x", sum);
        if ($urandom_range(1)) hx = hx.toupper();
        send_byte("$");
        for (int i = 0; i < pl.len(); i++) send_byte(8'(pl[i]));
        send_byte("#");
        send_byte(ck_mode == 2 ? "g" : 8'(hx[0]));
        send_byte(ck_mode == 3 ? "x" : 8'(hx[1]));
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- result check ----------------
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("result word with no packet pending: %h", m_tdata);
                failed = 1;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata[0] !== want.ack_ok) begin
                    $error("ack_ok exp %0d got %0d", want.ack_ok, m_tdata[0]); failed = 1;
                end
                if (m_tdata[2:1] !== want.req_class) begin
                    $error("request_class exp %0d got %0d", want.req_class, m_tdata[2:1]);
                    failed = 1;
                end
                if (m_tdata[7:3] !== want.command) begin
                    $error("command exp %0d got %0d", want.command, m_tdata[7:3]); failed = 1;
                end
                if (m_tdata[9:8] !== want.write_size) begin
                    $error("write_size exp %0d got %0d", want.write_size, m_tdata[9:8]);
                    failed = 1;
                end
                if (m_tdata[41:10] !== want.address) begin
                    $error("address exp %h got %h", want.address, m_tdata[41:10]); failed = 1;
                end
                if (m_tdata[73:42] !== want.data) begin
                    $error("data exp %h got %h", want.data, m_tdata[73:42]); failed = 1;
                end
            end
        end
    end

    int stuck_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= 5000) begin
            $display("[rsp_packet_receive_decode_top] ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic string hex_str(int n);
        string s, digs;
        int k;
        s = "";
        for (int i = 0; i < n; i++) begin
            digs = $urandom_range(1) ? "0123456789abcdef" : "0123456789ABCDEF";
            k = $urandom_range(15);
            s = {s, digs.substr(k, k)};
        end
        return s;
    endfunction

    function automatic string noise_str(int n);
        string s;
        byte c;
        s = "";
        for (int i = 0; i < n; i++) begin
            c = byte'($urandom_range(255));
            if (c == "#") c = "x";
            s = {s, string'(c)};
        end
        return s;
    endfunction

    function automatic string rand_payload();
        string s, pick;
        string singles;
        int k;
        singles = "?gscDkC";
        case ($urandom_range(10))
            0: s = {"m", hex_str($urandom_range(1, 10)), ",", hex_str($urandom_range(0, 4))};
            1: s = {"M", hex_str($urandom_range(1, 10)), ",", string'(byte'($urandom_range(48, 52))),
                    ":", hex_str($urandom_range(0, 10))};
            2: s = {"P", hex_str($urandom_range(1, 9)), "=", hex_str($urandom_range(0, 9))};
            3: s = {"p", hex_str($urandom_range(0, 9))};
            4: s = {$urandom_range(1) ? "z" : "Z", string'(byte'($urandom_range(48, 53))), ",",
                    hex_str($urandom_range(0, 9)), ",4"};
            5, 6: s = lit_str[$urandom_range(NUM_LIT - 1)];
            7: begin
                k = $urandom_range(6);
                pick = singles.substr(k, k);
                s = $urandom_range(3) == 0 ? {pick, "0"} : pick;
            end
            8: begin
                s = lit_str[$urandom_range(NUM_LIT - 1)];
                if ($urandom_range(1)) s = {s, noise_str(1)};
                else s = s.substr(0, s.len() - 2);
            end
            default: s = noise_str($urandom_range(0, 8));
        endcase
        return s;
    endfunction

    task automatic drain();
        stop_sending();
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_directed();
        string pk[$];
        pk = '{"qSupported:multiprocess+;qRelocInsn+", "Hg0", "Hc-1", "?", "qC",
               "qAttached", "qOffsets", "qTStatus", "qTfV", "qTfP", "g", "p1F",
               "mFFFFFFFF,ff", "qSymbol::", "vCont?", "M1000,3:DEADbeef", "P1f=123456789",
               "z0,abc,4", "z3,10,4", "Z0,7f,4", "Z4,ffffffff,4", "s", "c", "C05", "D"};
        foreach (pk[i]) send_packet(pk[i], 0);
        send_packet("k", 1);
        send_packet("p123456789abc", 0);                 // digits beyond 32 bits
        send_packet("M123456789,2:123456789", 0);        // 8-digit cap on M writes
        send_packet("m12", 0);                           // missing separator
        send_packet("z2", 0);                            // short breakpoint packet
        send_packet("g$g", 0);                           // start char inside payload
        send_packet("s", 2);
        send_packet("c", 3);
        send_packet("", 0);
        send_packet({"q", string'(byte'(8'hff)), string'(byte'(8'h01))}, 0);
        drain();
    endtask

    task automatic test_long_payload();
        string s;
        s = "p12";
        for (int i = 0; i < PAYLOAD_LIMIT + 6; i++) s = {s, "g"};
        send_packet(s, 0);
        drain();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_bytes);
        int start_bytes;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_bytes / 12) begin
            if ($urandom_range(4) == 0) begin
                for (int i = $urandom_range(1, 4); i > 0; i--) send_byte(8'($urandom_range(255)));
            end
            case ($urandom_range(19))
                0, 1, 2: send_packet(rand_payload(), 1);
                3: send_packet(rand_payload(), 2);
                4: send_packet(rand_payload(), 3);
                default: send_packet(rand_payload(), 0);
            endcase
        end
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (60) send_packet("g", 0);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        scan = PH_HUNT;
        clear_packet();
        test_directed();
        test_long_payload();
        test_random_traffic(0, 0, 280);
        test_random_traffic(49, 0, 280);
        test_random_traffic(0, 49, 280);
        test_random_traffic(19, 19, 280);
        test_backpressure();
        if (!failed) $display("[rsp_packet_receive_decode_top] OK");
        else $display("[rsp_packet_receive_decode_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rspd_pkg.sv
rtl/rspd_parser.sv
rtl/rspd_queue.sv
rtl/rspd_decoder.sv
rtl/rsp_packet_receive_decode_top.sv
verif/rsp_packet_receive_decode_top_test.sv
